// ----- sv/hcsc_pkg.sv -----
// Package: types, constants and hash helpers for the hashed call site counter.
package hcsc_pkg;

   localparam int NumClassesDef  = 15;
   localparam int TableSlotsDef  = 256;
   localparam int MaxProbesDef   = 32;

   localparam logic [31:0] SatMax   = 32'hFFFF_FFFF;
   localparam logic [31:0] MixMulA  = 32'h7feb352d;
   localparam logic [31:0] MixMulB  = 32'h846ca68b;

   typedef enum logic [1:0] {
      OUT_IGNORED  = 2'd0,
      OUT_COUNTED  = 2'd1,
      OUT_INSERTED = 2'd2,
      OUT_DROPPED  = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [3:0]  class_id;
      logic [31:0] return_address;
   } req_word_type;

   typedef struct packed {
      outcome_type outcome;
      logic [7:0]  entry_index;
      logic [31:0] site_count;
      logic [31:0] class_total;
      logic [31:0] class_dropped;
   } rsp_word_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == SatMax) ? v : v + 32'd1;
   endfunction

endpackage

// ----- sv/hcsc_mixer.sv -----
// Hash mixer: one shared 32x32 multiplier stepped through the two mixing rounds.
module hcsc_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] key,
   output logic        done,
   output logic [31:0] hash
);
   import hcsc_pkg::*;

   typedef enum logic [2:0] {
      M_IDLE, M_MUL1, M_MUL2, M_DONE
   } mstate_type;

   mstate_type  state_ff, state_in;
   logic [31:0] val_ff, val_in;
   logic [31:0] mul_a, mul_b, product;
   logic        done_ff, done_in;

   assign product = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      done_in  = 1'b0;
      mul_a    = val_ff;
      mul_b    = MixMulA;
      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               val_in   = key ^ (key >> 16);
               state_in = M_MUL1;
            end
         end
         M_MUL1: begin
            val_in   = product ^ (product >> 15);
            state_in = M_MUL2;
         end
         M_MUL2: begin
            mul_b    = MixMulB;
            val_in   = product ^ (product >> 16);
            state_in = M_DONE;
         end
         M_DONE: begin
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      val_ff <= val_in;
   end

   assign done = done_ff;
   assign hash = val_ff;

endmodule

// ----- sv/hashed_call_site_counter_top.sv -----
// Top level: hashed per-class call site counter with linear probing.
// Usage:
//   Drive req_word and pulse start while busy is low; the word is taken at that edge.
//   One rsp_word comes back per request, flagged by rsp_strobe for one cycle.
//   The receiver cannot stall; the strobe is never held.
// Steps, from the accepted word to the strobed response word:
//   Ignored request (class out of range or zero address): S_DONE raises the strobe.
//   Counted request: the hash on the mixer's shared multiplier, then per probe
//   a slot read (S_READ), then compare and update (S_CHECK), for 1 up to
//   MAX_PROBES probes, then S_DONE raises the strobe.
//   Dropped request: MAX_PROBES probes, then S_DROP, then S_DONE; the worst case.
//   One request at a time; busy falls in the strobe cycle, so the next word can be
//   taken at the edge that ends it.
// Reset:
//   After reset a clearing pass writes every slot to zero, one slot per cycle,
//   NUM_CLASSES*TABLE_SLOTS slots in all; busy is high throughout.
//   Class totals and drop counters are cleared at once.
module hashed_call_site_counter_top #(
   parameter int NUM_CLASSES = hcsc_pkg::NumClassesDef,
   parameter int MAX_PROBES  = hcsc_pkg::MaxProbesDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  hcsc_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output hcsc_pkg::rsp_word_type rsp_word
);
   import hcsc_pkg::*;

   localparam int TABLE_SLOTS = TableSlotsDef;
   localparam int SlotBits  = $clog2(TABLE_SLOTS);
   localparam int Depth     = NUM_CLASSES * TABLE_SLOTS;
   localparam int AddrBits  = $clog2(Depth);
   localparam int ProbeBits = $clog2(MAX_PROBES + 1);
   localparam int ClsBits   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_DROP, S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [AddrBits-1:0]   clr_ff, clr_in;
   logic [ClsBits-1:0]    cls_ff, cls_in;
   logic [31:0]           addr_ff, addr_in;
   logic [SlotBits-1:0]   slot_ff, slot_in;
   logic [ProbeBits-1:0]  probe_ff, probe_in;
   rsp_word_type          rsp_ff, rsp_in;
   logic                  strobe_ff, strobe_in;
   logic [31:0]           totals_ff [NUM_CLASSES];
   logic [31:0]           drops_ff  [NUM_CLASSES];

   logic [31:0]           key_mem   [Depth];
   logic [31:0]           count_mem [Depth];
   logic [31:0]           key_rd_ff, count_rd_ff;
   logic                  wr_en;
   logic [AddrBits-1:0]   wr_addr, rd_addr;
   logic [31:0]           wr_key, wr_count;

   logic                  mix_start, mix_done;
   logic [31:0]           mix_hash;
   logic                  valid_req;
   logic [31:0]           new_total, new_drop, new_count;
   logic [AddrBits-1:0]   base_addr;

   hcsc_mixer u_mixer (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .key   (addr_ff),
      .done  (mix_done),
      .hash  (mix_hash)
   );

   assign valid_req = ({28'd0, req_word.class_id} < 32'(NUM_CLASSES))
                      && (req_word.return_address != 32'd0);
   assign base_addr = AddrBits'(cls_ff) * AddrBits'(TABLE_SLOTS);
   assign rd_addr   = base_addr + AddrBits'(slot_ff);
   assign new_total = sat_inc(totals_ff[cls_ff]);
   assign new_drop  = sat_inc(drops_ff[cls_ff]);
   assign new_count = (key_rd_ff == 32'd0) ? 32'd1 : sat_inc(count_rd_ff);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cls_in    = cls_ff;
      addr_in   = addr_ff;
      slot_in   = slot_ff;
      probe_in  = probe_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      mix_start = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = rd_addr;
      wr_key    = addr_ff;
      wr_count  = new_count;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            wr_key   = 32'd0;
            wr_count = 32'd0;
            clr_in   = clr_ff + AddrBits'(1);
            if (clr_ff == AddrBits'(Depth - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cls_in  = ClsBits'(req_word.class_id);
               addr_in = req_word.return_address;
               rsp_in  = '0;
               if (valid_req) begin
                  state_in = S_HASH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_HASH: begin
            mix_start = (probe_ff == '0) && !mix_done;
            probe_in  = ProbeBits'(1);
            if (mix_done) begin
               slot_in  = mix_hash[SlotBits-1:0];
               probe_in = '0;
               rsp_in.class_total = new_total;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (key_rd_ff == addr_ff || key_rd_ff == 32'd0) begin
               wr_en = 1'b1;
               rsp_in.outcome       = (key_rd_ff == 32'd0) ? OUT_INSERTED : OUT_COUNTED;
               rsp_in.entry_index   = 8'(slot_ff);
               rsp_in.site_count    = new_count;
               rsp_in.class_dropped = drops_ff[cls_ff];
               state_in = S_DONE;
            end else if (probe_ff == ProbeBits'(MAX_PROBES - 1)) begin
               state_in = S_DROP;
            end else begin
               probe_in = probe_ff + ProbeBits'(1);
               slot_in  = slot_ff + SlotBits'(1);
               state_in = S_READ;
            end
         end
         S_DROP: begin
            rsp_in.outcome       = OUT_DROPPED;
            rsp_in.class_dropped = new_drop;
            state_in = S_DONE;
         end
         S_DONE: begin
            strobe_in = 1'b1;
            probe_in  = '0;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         probe_ff  <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            totals_ff[i] <= '0;
            drops_ff[i]  <= '0;
         end
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         probe_ff  <= probe_in;
         strobe_ff <= strobe_in;
         if (state_ff == S_HASH && mix_done) totals_ff[cls_ff] <= new_total;
         if (state_ff == S_DROP) drops_ff[cls_ff] <= new_drop;
      end
      cls_ff  <= cls_in;
      addr_ff <= addr_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         count_mem[wr_addr] <= wr_count;
      end
      key_rd_ff   <= key_mem[rd_addr];
      count_rd_ff <= count_mem[rd_addr];
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ----- sv/hcsc_checker.sv -----
// Port-level checker for the hashed call site counter, bound to the top level.
module hcsc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input hcsc_pkg::rsp_word_type rsp_word,
   input logic                   rsp_strobe
);
   import hcsc_pkg::*;

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy low after accepted word");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("strobe without pending word");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe longer than one cycle");

   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.outcome == OUT_IGNORED |->
      rsp_word.class_total == 32'd0 && rsp_word.site_count == 32'd0)
      else $error("ignored word carries data");

   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.outcome == OUT_DROPPED |->
      rsp_word.entry_index == 8'd0 && rsp_word.class_dropped != 32'd0)
      else $error("dropped word inconsistent");

endmodule

bind hashed_call_site_counter_top hcsc_checker u_hcsc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_word   (rsp_word),
   .rsp_strobe (rsp_strobe)
);

// ----- verif/hashed_call_site_counter_checker.sv -----
// Checker: predicts per-class call site counts and compares every response word.
`timescale 1ns / 1ps
module hashed_call_site_counter_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  hcsc_pkg::req_word_type req_word,
   input  logic                   rsp_strobe,
   input  hcsc_pkg::rsp_word_type rsp_word,
   output int                     fail_count,
   output int                     pending_count,
   output int                     counted_words,
   output int                     dropped_words
);
   import hcsc_pkg::*;

   localparam int Classes = NumClassesDef;
   localparam int Slots   = TableSlotsDef;
   localparam int Probes  = MaxProbesDef;

   logic [31:0] key_store   [Classes*Slots];
   logic [31:0] count_store [Classes*Slots];
   logic [31:0] total_store [Classes];
   logic [31:0] drop_store  [Classes];
   rsp_word_type expected_words[$];

   function automatic logic [31:0] mix_address(input logic [31:0] a);
      logic [31:0] x;
      x = a ^ (a >> 16);
      x = x * 32'h7feb352d;
      x = x ^ (x >> 15);
      x = x * 32'h846ca68b;
      x = x ^ (x >> 16);
      return x;
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic rsp_word_type count_site(input req_word_type w);
      rsp_word_type r;
      int base, slot, idx;
      r = '0;
      r.outcome = OUT_IGNORED;
      if (w.class_id >= Classes || w.return_address == 32'd0) return r;
      total_store[w.class_id] = bump(total_store[w.class_id]);
      r.class_total = total_store[w.class_id];
      base = w.class_id * Slots;
      slot = mix_address(w.return_address) % Slots;
      for (int p = 0; p < Probes; p++) begin
         idx = base + slot;
         if (key_store[idx] == w.return_address || key_store[idx] == 32'd0) begin
            r.outcome = (key_store[idx] == 32'd0) ? OUT_INSERTED : OUT_COUNTED;
            key_store[idx] = w.return_address;
            count_store[idx] = bump(count_store[idx]);
            r.entry_index = slot[7:0];
            r.site_count = count_store[idx];
            r.class_dropped = drop_store[w.class_id];
            return r;
         end
         slot = (slot + 1) % Slots;
      end
      drop_store[w.class_id] = bump(drop_store[w.class_id]);
      r.outcome = OUT_DROPPED;
      r.class_dropped = drop_store[w.class_id];
      return r;
   endfunction

   initial begin
      foreach (key_store[i]) key_store[i] = '0;
      foreach (count_store[i]) count_store[i] = '0;
      foreach (total_store[i]) total_store[i] = '0;
      foreach (drop_store[i]) drop_store[i] = '0;
      fail_count = 0;
      counted_words = 0;
      dropped_words = 0;
   end

   assign pending_count = expected_words.size();

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               $error("response word with nothing expected");
               fail_count++;
            end else begin
               e = expected_words.pop_front();
               if (rsp_word.outcome !== e.outcome) begin
                  $error("outcome exp %0d got %0d", e.outcome, rsp_word.outcome);
                  fail_count++;
               end
               if (rsp_word.entry_index !== e.entry_index) begin
                  $error("entry_index exp %0d got %0d", e.entry_index, rsp_word.entry_index);
                  fail_count++;
               end
               if (rsp_word.site_count !== e.site_count) begin
                  $error("site_count exp %0d got %0d", e.site_count, rsp_word.site_count);
                  fail_count++;
               end
               if (rsp_word.class_total !== e.class_total) begin
                  $error("class_total exp %0d got %0d", e.class_total, rsp_word.class_total);
                  fail_count++;
               end
               if (rsp_word.class_dropped !== e.class_dropped) begin
                  $error("class_dropped exp %0d got %0d", e.class_dropped,
                         rsp_word.class_dropped);
                  fail_count++;
               end
               if (e.outcome == OUT_COUNTED || e.outcome == OUT_INSERTED) counted_words++;
               if (e.outcome == OUT_DROPPED) dropped_words++;
            end
         end
         if (start && !busy) expected_words = {expected_words, count_site(req_word)};
      end
   end
endmodule

// ----- verif/tb_hashed_call_site_counter_top.sv -----
// Testbench top: drives request words into the hashed call site counter and gives the verdict.
`timescale 1ns / 1ps
module tb_hashed_call_site_counter_top;
   import hcsc_pkg::*;

   logic clock, reset, start, busy, rsp_strobe;
   req_word_type req_word;
   rsp_word_type rsp_word;
   int fail_count, pending_count, counted_words, dropped_words;
   int idle_cycles, sent_words;
   logic [31:0] hot_sites[8];
   logic [31:0] crowd_sites[$];

   hashed_call_site_counter_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   hashed_call_site_counter_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending_count(pending_count),
      .counted_words(counted_words), .dropped_words(dropped_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: the limit outlasts both the clearing pass and the longest word
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] mix_address(input logic [31:0] a);
      logic [31:0] x;
      x = a ^ (a >> 16);
      x = x * 32'h7feb352d;
      x = x ^ (x >> 15);
      x = x * 32'h846ca68b;
      return x ^ (x >> 16);
   endfunction

   task automatic send_word(input logic [3:0] cls, input logic [31:0] addr, input bit gaps);
      if (gaps) begin
         while ($urandom_range(99) < 13) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_word <= '{class_id: cls, return_address: addr};
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_words++;
   endtask

   initial begin
      logic [31:0] a;
      logic [31:0] h;
      idle_cycles = 0;
      sent_words = 0;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_word(4'd0, 32'h0000_0001, 1'b0);
      send_word(4'd0, 32'h0000_0001, 1'b0);
      send_word(4'd14, 32'hFFFF_FFFF, 1'b0);
      send_word(4'd15, 32'h1234_5678, 1'b0);
      send_word(4'd3, 32'h0, 1'b0);
      send_word(4'd15, 32'h0, 1'b0);
      send_word(4'd7, 32'hAAAA_AAAA, 1'b0);
      send_word(4'd8, 32'h5555_5555, 1'b0);
      // fill one class home run with colliding addresses to force drops
      a = 32'd1;
      while (crowd_sites.size() < 40) begin
         h = mix_address(a);
         if (h[7:0] == 8'd250) crowd_sites = {crowd_sites, a};
         a++;
      end
      foreach (crowd_sites[i]) send_word(4'd5, crowd_sites[i], 1'b0);
      send_word(4'd5, crowd_sites[0], 1'b0);
      send_word(4'd5, crowd_sites[39], 1'b0);
      // drain before random traffic
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      foreach (hot_sites[i]) hot_sites[i] = $urandom() | 32'd1;
      for (int n = 0; n < 1000; n++) begin
         int pick;
         logic [3:0] cls;
         pick = $urandom_range(99);
         cls = 4'($urandom_range(14));
         if (pick < 40) send_word(cls & 4'd3, hot_sites[$urandom_range(7)], n < 300 || n > 400);
         else if (pick < 55) send_word(4'd5, crowd_sites[$urandom_range(39)], n < 300 || n > 400);
         else if (pick < 90) send_word(cls, $urandom(), n < 300 || n > 400);
         else send_word(4'($urandom_range(15)), ($urandom_range(1)) ? 32'd0 : $urandom(),
                        n < 300 || n > 400);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d request words: %0d counted, %0d dropped after full probe runs.",
               sent_words, counted_words, dropped_words);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ----- sim.f -----
sv/hcsc_pkg.sv
sv/hcsc_mixer.sv
sv/hashed_call_site_counter_top.sv
sv/hcsc_checker.sv
verif/hashed_call_site_counter_checker.sv
verif/tb_hashed_call_site_counter_top.sv
